// ===== rtl/scan_polar_to_cartesian_core_assert.svh =====
// assertion macros for the polar to cartesian scan core
// expects clk and rst_n in the scope where a macro is used
`ifndef SCAN_POLAR_TO_CARTESIAN_CORE_ASSERT_SVH
`define SCAN_POLAR_TO_CARTESIAN_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SP2C_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sp2c assertion failed");
// next-cycle implication
`define SP2C_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sp2c assertion failed");
`else
`define SP2C_ASSERT_NOW(label, ante, cons)
`define SP2C_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/sp2c_pkg.sv =====
// shared types, constants and arctangent table of the scan converter
// no dependencies
`default_nettype none
package sp2c_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int RANGE_BITS_DEF    = 16;
  localparam int TABLE_LEN         = 24;
  localparam int PHASE_W           = 32;
  localparam int GAIN_BITS         = 16;
  localparam int OUT_LIMIT         = 65535;
  localparam int ROUND_HALF        = 32768;
  localparam int CFG_W             = 16;
  localparam int CFG_IDX_W         = 3;
  localparam int COORD_W           = 17;

  // cordic gain compensation, 0.60725 in q16
  localparam logic [GAIN_BITS-1:0] GAIN_Q16 = 16'd39797;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_MIN_RANGE   = 3'd2,
    REG_MAX_RANGE   = 3'd3
  } sp2c_reg_t;

  // control bits that ride along with each item
  typedef struct packed {
    logic vld;
    logic keep;
    logic last;
  } sp2c_tag_t;

  // atan(2^-i), 2^32 units per turn, truncated
  localparam logic [PHASE_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage
`default_nettype wire

// ===== rtl/scan_polar_to_cartesian_core.sv =====
// top level of the lidar scan polar to cartesian converter
// depends on sp2c_pkg, sp2c_cell and scan_polar_to_cartesian_core_assert.svh
//
// Takes one range sample per item and returns one point per item, in order:
// x = r*cos(angle), y = r*sin(angle), rounded and clipped to +/-65535, or zero
// with kept low when r is not strictly between min_range and max_range. The
// beam angle takes start_angle on the first sample of a scan and advances by
// angle_step after every sample. A new item is accepted every clock unless the
// output is stalled; a point passes the input register, gain prescale register,
// one register per cordic cell and the output register, in that order.
// The whole chain moves together, so a stalled output holds every stage and
// raises in_stall. No clearing pass after reset.
`default_nettype none
module scan_polar_to_cartesian_core #(
  parameter int CORDIC_STAGES = sp2c_pkg::CORDIC_STAGES_DEF,
  parameter int RANGE_BITS    = sp2c_pkg::RANGE_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // configuration
  input  wire                                  cfg_we,
  input  wire [sp2c_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [sp2c_pkg::CFG_W-1:0]            cfg_wdata,
  // samples
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [15:0]                           in_range_sample,
  input  wire                                  in_last_in_scan,
  // points
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [sp2c_pkg::COORD_W-1:0]  out_x_coord,
  output logic signed [sp2c_pkg::COORD_W-1:0]  out_y_coord,
  output logic                                 out_kept,
  output logic                                 out_end_of_scan
);
  import sp2c_pkg::*;

  `include "scan_polar_to_cartesian_core_assert.svh"

  localparam int XW = RANGE_BITS + GAIN_BITS + 3;
  localparam int RW = XW - 15;
  localparam int SW = (RW > 18) ? RW : 18;
  localparam int CW = (RANGE_BITS > 16) ? RANGE_BITS : 16;
  localparam logic signed [SW-1:0] LIM_P = SW'(OUT_LIMIT);
  localparam logic signed [SW-1:0] LIM_N = SW'(-OUT_LIMIT);

  // configuration registers
  logic [15:0] start_angle_r, angle_step_r, min_range_r, max_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= '0;
      angle_step_r  <= '0;
      min_range_r   <= '0;
      max_range_r   <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_ANGLE: start_angle_r <= cfg_wdata;
        REG_ANGLE_STEP:  angle_step_r  <= cfg_wdata;
        REG_MIN_RANGE:   min_range_r   <= cfg_wdata;
        REG_MAX_RANGE:   max_range_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // chain advance: everything moves unless a finished point is held
  logic adv, in_acc;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  // beam angle tracking
  logic [15:0]           beam_angle_r, beam_angle_nxt, ang_cur;
  logic                  at_scan_start_r, at_scan_start_nxt;
  logic [RANGE_BITS-1:0] r_cur;
  logic                  keep_cur;

  always_comb begin
    ang_cur           = at_scan_start_r ? start_angle_r : beam_angle_r;
    beam_angle_nxt    = ang_cur + angle_step_r;
    at_scan_start_nxt = in_last_in_scan;
    r_cur             = RANGE_BITS'(in_range_sample);
    keep_cur          = (CW'(r_cur) > CW'(min_range_r)) && (CW'(r_cur) < CW'(max_range_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_angle_r    <= '0;
      at_scan_start_r <= 1'b1;
    end else if (in_acc) begin
      beam_angle_r    <= beam_angle_nxt;
      at_scan_start_r <= at_scan_start_nxt;
    end
  end

  // input register
  sp2c_tag_t             a_tag_r;
  logic [RANGE_BITS-1:0] a_r_r;
  logic [15:0]           a_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r <= '0;
    end else if (adv) begin
      a_tag_r <= '{vld: in_valid, keep: keep_cur, last: in_last_in_scan};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r_r   <= r_cur;
      a_ang_r <= ang_cur;
    end
  end

  // gain prescale and quadrant fold
  logic [RANGE_BITS+GAIN_BITS-1:0] prod;
  logic signed [XW-1:0]            x_pos, x0_nxt;
  logic                            fold;
  logic [15:0]                     ang_fold;
  logic signed [PHASE_W-1:0]       z0_nxt;

  always_comb begin
    prod     = a_r_r * GAIN_Q16;
    x_pos    = XW'(prod);
    fold     = a_ang_r[15] ^ a_ang_r[14];
    x0_nxt   = fold ? -x_pos : x_pos;
    ang_fold = {a_ang_r[15] ^ fold, a_ang_r[14:0]};
    z0_nxt   = {ang_fold, 16'h0000};
  end

  sp2c_tag_t                 tag_ch [CORDIC_STAGES+1];
  logic signed [XW-1:0]      x_ch   [CORDIC_STAGES+1];
  logic signed [XW-1:0]      y_ch   [CORDIC_STAGES+1];
  logic signed [PHASE_W-1:0] z_ch   [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_ch[0] <= '0;
    end else if (adv) begin
      tag_ch[0] <= a_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_ch[0] <= x0_nxt;
      y_ch[0] <= '0;
      z_ch[0] <= z0_nxt;
    end
  end

  // row of rotation cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    sp2c_cell #(
      .STAGE (i),
      .XW    (XW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .tag_in  (tag_ch[i]),
      .x_in    (x_ch[i]),
      .y_in    (y_ch[i]),
      .z_in    (z_ch[i]),
      .tag_out (tag_ch[i+1]),
      .x_out   (x_ch[i+1]),
      .y_out   (y_ch[i+1]),
      .z_out   (z_ch[i+1])
    );
  end

  // round to nearest, ties toward +inf, then clip
  logic signed [XW:0]   x_bias, y_bias;
  logic signed [SW-1:0] x_sat, y_sat, x_clip, y_clip;
  sp2c_tag_t            t_end;

  always_comb begin
    t_end  = tag_ch[CORDIC_STAGES];
    x_bias = (XW+1)'(x_ch[CORDIC_STAGES]) + (XW+1)'(ROUND_HALF);
    y_bias = (XW+1)'(y_ch[CORDIC_STAGES]) + (XW+1)'(ROUND_HALF);
    x_sat  = SW'($signed(x_bias[XW:16]));
    y_sat  = SW'($signed(y_bias[XW:16]));
    if (x_sat > LIM_P)      x_clip = LIM_P;
    else if (x_sat < LIM_N) x_clip = LIM_N;
    else                    x_clip = x_sat;
    if (y_sat > LIM_P)      y_clip = LIM_P;
    else if (y_sat < LIM_N) y_clip = LIM_N;
    else                    y_clip = y_sat;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= t_end.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_coord     <= t_end.keep ? x_clip[COORD_W-1:0] : '0;
      out_y_coord     <= t_end.keep ? y_clip[COORD_W-1:0] : '0;
      out_kept        <= t_end.keep;
      out_end_of_scan <= t_end.last;
    end
  end

  // checks
  `SP2C_ASSERT_NOW(a_drop_zero, out_valid && !out_kept, out_x_coord == 0 && out_y_coord == 0)
  `SP2C_ASSERT_NOW(a_keep_limits, out_valid && out_kept, min_range_r < max_range_r)
  `SP2C_ASSERT_NEXT(a_scan_restart, in_acc, at_scan_start_r == $past(in_last_in_scan))
  `SP2C_ASSERT_NEXT(a_hold_chain, !adv, $stable(tag_ch[CORDIC_STAGES]) && out_valid)
  `SP2C_ASSERT_NOW(a_x_bound, out_valid, out_x_coord != COORD_W'(-65536))

endmodule
`default_nettype wire

// ===== rtl/sp2c_cell.sv =====
// one cordic rotation cell: shift-add micro-rotation by atan(2^-STAGE)
// depends on sp2c_pkg
`default_nettype none
module sp2c_cell #(
  parameter int STAGE = 0,
  parameter int XW    = 35
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              en,
  input  wire sp2c_pkg::sp2c_tag_t         tag_in,
  input  wire logic signed [XW-1:0]        x_in,
  input  wire logic signed [XW-1:0]        y_in,
  input  wire logic signed [sp2c_pkg::PHASE_W-1:0] z_in,
  output sp2c_pkg::sp2c_tag_t              tag_out,
  output logic signed [XW-1:0]             x_out,
  output logic signed [XW-1:0]             y_out,
  output logic signed [sp2c_pkg::PHASE_W-1:0] z_out
);
  import sp2c_pkg::*;

  localparam logic signed [PHASE_W-1:0] ANGLE = ATAN_TAB[STAGE];

  sp2c_tag_t                  tag_r;
  logic signed [XW-1:0]       x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [PHASE_W-1:0]  z_r, z_nxt;

  // rotate toward zero residual phase
  always_comb begin
    dx = y_in >>> STAGE;
    dy = x_in >>> STAGE;
    if (!z_in[PHASE_W-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - ANGLE;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + ANGLE;
    end
  end

  // control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_in;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign tag_out = tag_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule
`default_nettype wire

// ===== tb/sp2c_point_checker.sv =====
`timescale 1ns / 1ps
// scoreboard of the scan converter: follows the register, sample and point ports,
// predicts every point with its own fixed-point cordic model and compares in order
// depends on sp2c_pkg for port widths and register indexes
module sp2c_point_checker #(
  parameter int CORDIC_STAGES = 16,
  parameter int RANGE_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sp2c_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sp2c_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [15:0]                         in_range_sample,
  input  logic                                in_last_in_scan,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [sp2c_pkg::COORD_W-1:0] out_x_coord,
  input  logic signed [sp2c_pkg::COORD_W-1:0] out_y_coord,
  input  logic                                out_kept,
  input  logic                                out_end_of_scan,
  output int                                  fail_count,
  output int                                  points_pending
);
  import sp2c_pkg::*;

  localparam longint GAIN_COMP   = 39797;
  localparam longint ROUND_BIAS  = 32768;
  localparam longint COORD_MAX   = 65535;
  localparam int     ATAN_LEN    = 24;
  localparam logic [15:0] RANGE_KEEP = 16'((64'd1 << RANGE_BITS) - 64'd1);

  // atan(2^-i) in 2^32 units per turn, truncated
  localparam longint ATAN_TURN [ATAN_LEN] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
    'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
    'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C,
    'h000028BE, 'h0000145F, 'h00000A2F, 'h00000517,
    'h0000028B, 'h00000145, 'h000000A2, 'h00000051
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      kept;
    logic                      eos;
  } point_t;

  point_t      expected_points[$];
  point_t      want;
  int          mismatches;
  logic [15:0] start_angle, angle_step, min_range, max_range;
  logic [15:0] beam_angle;
  logic        at_scan_start;
  logic [15:0] r;
  logic        keep;

  // round to nearest (floor of v + half) and clip to the coordinate range
  function automatic logic signed [COORD_W-1:0] round_clip(input longint v);
    longint q;
    q = (v + ROUND_BIAS) >>> 16;
    if (q > COORD_MAX) q = COORD_MAX;
    else if (q < -COORD_MAX) q = -COORD_MAX;
    return q[COORD_W-1:0];
  endfunction

  // rotate (r * gain compensation, 0) by the beam angle
  function automatic point_t rotate_range(input logic [15:0] rng, input logic [15:0] ang);
    point_t      p;
    logic [31:0] ph;
    longint      xa, ya, za, dx, dy;
    int          i;
    p  = '0;
    ph = {ang, 16'h0000};
    xa = rng;
    xa = xa * GAIN_COMP;
    ya = 0;
    // second and third quadrant: flip the vector and turn by half a turn
    if (ph[31:30] == 2'b01 || ph[31:30] == 2'b10) begin
      xa = -xa;
      ph = ph + 32'h8000_0000;
    end
    za = $signed(ph);
    for (i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      dx = ya >>> i;
      dy = xa >>> i;
      if (za >= 0) begin
        xa = xa - dx;
        ya = ya + dy;
        za = za - ATAN_TURN[i];
      end else begin
        xa = xa + dx;
        ya = ya - dy;
        za = za + ATAN_TURN[i];
      end
    end
    p.x = round_clip(xa);
    p.y = round_clip(ya);
    return p;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start_angle   = '0;
      angle_step    = '0;
      min_range     = '0;
      max_range     = 16'hFFFF;
      beam_angle    = '0;
      at_scan_start = 1'b1;
      mismatches    = 0;
      expected_points.delete();
    end else begin
      // compare a delivered point against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          $display("%0t: point with none expected: got x=%0d y=%0d kept=%0b end=%0b",
                   $time, out_x_coord, out_y_coord, out_kept, out_end_of_scan);
        end else begin
          want = expected_points.pop_front();
          if (out_x_coord !== want.x || out_y_coord !== want.y ||
              out_kept !== want.kept || out_end_of_scan !== want.eos) begin
            mismatches++;
            $display("%0t: point mismatch: expected x=%0d y=%0d kept=%0b end=%0b,",
                     $time, want.x, want.y, want.kept, want.eos,
                     " got x=%0d y=%0d kept=%0b end=%0b",
                     out_x_coord, out_y_coord, out_kept, out_end_of_scan);
          end
        end
      end

      // predict the point of an accepted sample and advance the beam
      if (in_valid && !in_stall) begin
        r = in_range_sample & RANGE_KEEP;
        if (at_scan_start) beam_angle = start_angle;
        keep = (r > min_range) && (r < max_range);
        want = keep ? rotate_range(r, beam_angle) : point_t'('0);
        want.kept = keep;
        want.eos  = in_last_in_scan;
        expected_points = {expected_points, want};
        beam_angle    = beam_angle + angle_step;
        at_scan_start = in_last_in_scan;
      end

      // register writes; spare indexes are ignored
      if (cfg_we) begin
        case (cfg_index)
          REG_START_ANGLE: start_angle = cfg_wdata;
          REG_ANGLE_STEP:  angle_step  = cfg_wdata;
          REG_MIN_RANGE:   min_range   = cfg_wdata;
          REG_MAX_RANGE:   max_range   = cfg_wdata;
          default: ;
        endcase
      end
    end
    points_pending <= expected_points.size();
    fail_count     <= mismatches;
  end

endmodule

// ===== tb/scan_polar_to_cartesian_core_tb.sv =====
`timescale 1ns / 1ps
// testbench top of the scan converter: clock, reset, register writes, samples and
// point draining with random pauses, and the verdict
// depends on sp2c_pkg, sp2c_point_checker and scan_polar_to_cartesian_core
module scan_polar_to_cartesian_core_tb;
  import sp2c_pkg::*;

  localparam int PIPE_DEPTH     = CORDIC_STAGES_DEF + 3;
  localparam int DRAIN_CYCLES   = 2 * PIPE_DEPTH;
  localparam int LONG_HOLD      = 300;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_SAMPLES  = 100;
  localparam int PRESSURE_PHASE = 1;
  localparam int NUM_REGS       = 4;
  localparam int MAX_PAUSE      = 6;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_wdata;
  logic                      in_valid;
  wire                       in_stall;
  logic [15:0]               in_range_sample;
  logic                      in_last_in_scan;
  wire                       out_valid;
  logic                      out_stall;
  wire signed [COORD_W-1:0]  out_x_coord;
  wire signed [COORD_W-1:0]  out_y_coord;
  wire                       out_kept;
  wire                       out_end_of_scan;
  int                        fail_count;
  int                        points_pending;
  int                        cycle_count = 0;
  bit                        tx_calm = 1'b0;
  bit                        rx_calm = 1'b0;
  int                        hold_orders = 0;
  int                        holds_served = 0;

  scan_polar_to_cartesian_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_range_sample (in_range_sample),
    .in_last_in_scan (in_last_in_scan),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_coord     (out_x_coord),
    .out_y_coord     (out_y_coord),
    .out_kept        (out_kept),
    .out_end_of_scan (out_end_of_scan)
  );

  sp2c_point_checker #(
    .CORDIC_STAGES (CORDIC_STAGES_DEF),
    .RANGE_BITS    (RANGE_BITS_DEF)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_range_sample (in_range_sample),
    .in_last_in_scan (in_last_in_scan),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_coord     (out_x_coord),
    .out_y_coord     (out_y_coord),
    .out_kept        (out_kept),
    .out_end_of_scan (out_end_of_scan),
    .fail_count      (fail_count),
    .points_pending  (points_pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // point receiver: random stall before each item, one long hold on request
  initial begin
    int wait_len;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_orders != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        wait_len = rx_calm ? 0 : $urandom_range(MAX_PAUSE, 0);
        if (wait_len != 0) begin
          out_stall <= 1'b1;
          repeat (wait_len) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // offer one sample after a random gap and hold it until taken
  task automatic send_sample(input logic [15:0] rng, input logic last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(MAX_PAUSE, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_range_sample <= rng;
    in_last_in_scan <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and let every predicted point drain out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all four registers plus one spare index while idle
  task automatic configure(input logic [15:0] start, input logic [15:0] step,
                           input logic [15:0] lo, input logic [15:0] hi);
    logic [CFG_IDX_W-1:0] spare_idx;
    settle();
    spare_idx = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, NUM_REGS));
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_ANGLE;
    cfg_wdata <= start;
    @(posedge clk);
    cfg_index <= REG_ANGLE_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_index <= REG_MIN_RANGE;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= REG_MAX_RANGE;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_index <= spare_idx;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          lo, hi, scan_len, sent, phase, k;
    logic [15:0] sa, st, rng;
    logic        last;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_range_sample = '0;
    in_last_in_scan = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // quarter-turn steps through all four axes, range limits at defaults
    configure(16'h0000, 16'h4000, 16'h0000, 16'hFFFF);
    send_sample(16'hFFFE, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'd12345, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'd40000, 1'b1);

    // start at half a turn, largest positive step
    configure(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
    send_sample(16'd50000, 1'b0);
    send_sample(16'd50000, 1'b0);
    send_sample(16'd50000, 1'b0);
    send_sample(16'd50000, 1'b1);

    // quadrant boundary at three quarters, tight window around one range
    configure(16'hBFFF, 16'h0001, 16'd1000, 16'd1002);
    send_sample(16'd1001, 1'b0);
    send_sample(16'd1000, 1'b0);
    send_sample(16'd1002, 1'b1);

    // quadrant boundary at one quarter
    configure(16'h3FFF, 16'h0001, 16'h0000, 16'hFFFF);
    send_sample(16'd20000, 1'b0);
    send_sample(16'd20000, 1'b1);

    // equal limits keep nothing
    configure(16'h1234, 16'hFFFF, 16'd500, 16'd500);
    send_sample(16'd500, 1'b0);
    send_sample(16'd499, 1'b0);
    send_sample(16'd501, 1'b1);

    // crossed limits at the extremes
    configure(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);

    // random phases: scans of random length under random settings
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(5, 0))
        0:       sa = 16'h0000;
        1:       sa = 16'h7FFF;
        2:       sa = 16'h8000;
        3:       sa = 16'hFFFF;
        default: sa = 16'($urandom);
      endcase
      case ($urandom_range(6, 0))
        0:       st = 16'h0000;
        1:       st = 16'h0001;
        2:       st = 16'h7FFF;
        3:       st = 16'h8000;
        4:       st = 16'hFFFF;
        default: st = 16'($urandom);
      endcase
      case ($urandom_range(7, 0))
        0: begin lo = 0; hi = 65535; end
        1: begin lo = $urandom_range(65535, 0); hi = $urandom_range(65535, 0); end
        2: begin lo = $urandom_range(65535, 0); hi = lo; end
        default: begin lo = $urandom_range(2000, 0); hi = $urandom_range(65535, 60000); end
      endcase
      configure(sa, st, 16'(lo), 16'(hi));

      // one phase holds the points back so the pipeline fills
      if (phase == PRESSURE_PHASE) begin
        tx_calm = 1'b1;
        rx_calm <= 1'b0;
        hold_orders <= hold_orders + 1;
      end else begin
        tx_calm = ($urandom_range(3, 0) == 0);
        rx_calm <= ($urandom_range(3, 0) == 0);
      end

      sent = 0;
      while (sent < PHASE_SAMPLES) begin
        scan_len = $urandom_range(40, 1);
        for (k = 0; k < scan_len; k++) begin
          if ($urandom_range(4, 0) != 0 && lo + 1 < hi)
            rng = 16'($urandom_range(hi - 1, lo + 1));
          else
            rng = 16'($urandom);
          last = (k == scan_len - 1) || ($urandom_range(31, 0) == 0);
          send_sample(rng, last);
          sent++;
        end
      end
    end

    settle();
    if (fail_count == 0 && points_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sp2c_pkg.sv
rtl/sp2c_cell.sv
rtl/scan_polar_to_cartesian_core.sv
tb/sp2c_point_checker.sv
tb/scan_polar_to_cartesian_core_tb.sv
